// ===== src/murmur3_32bit_stream_hash_assert.svh =====
// Assertion macros for the murmur3 stream hash RTL.
`ifndef MURMUR3_32BIT_STREAM_HASH_ASSERT_SVH
`define MURMUR3_32BIT_STREAM_HASH_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define MMH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define MMH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MMH_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define MMH_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/mmh_pkg.sv =====
// Constants and control types for the murmur3 x86_32 stream hash.
`timescale 1ns / 1ps
package mmh_pkg;

  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 3;
  localparam int unsigned TdataW = 40;  // word + count, padded to bytes

  localparam logic [CountW-1:0] FullCount = 3'd4;

  localparam logic [WordW-1:0] KeyC1   = 32'hcc9e2d51;
  localparam logic [WordW-1:0] KeyC2   = 32'h1b873593;
  localparam logic [WordW-1:0] HashMix = 32'he6546b64;
  localparam logic [WordW-1:0] FinM1   = 32'h85ebca6b;
  localparam logic [WordW-1:0] FinM2   = 32'hc2b2ae35;

  localparam int unsigned KeyRot  = 15;
  localparam int unsigned HashRot = 13;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;  // take input item, key times C1
    logic mul2;    // key times C2
    logic acc;     // fold key into hash, advance length
    logic fin1;    // finalizer first multiply
    logic fin2;    // finalizer second multiply
    logic fin3;    // load output register
  } mmh_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic last;      // item in flight is the final word
    logic out_busy;  // output register full and not taken this cycle
  } mmh_sts_t;

  function automatic logic [WordW-1:0] rotl15(input logic [WordW-1:0] v);
    return {v[WordW-KeyRot-1:0], v[WordW-1:WordW-KeyRot]};
  endfunction

  function automatic logic [WordW-1:0] rotl13(input logic [WordW-1:0] v);
    return {v[WordW-HashRot-1:0], v[WordW-1:WordW-HashRot]};
  endfunction

endpackage

// ===== src/murmur3_32bit_stream_hash.sv =====
// Top level of the murmur3 x86_32 stream hash: controller plus datapath.
// The single shared 32x32 multiplier serves two key multiplies per word and the
//   finalizer multiplies; the hash fold follows them, so a new word waits for the fold.
// After a last word: MIX2, ACC, FIN1, FIN2, then FIN3 loads the hash into the output
//   register and the next word is accepted back in IDLE, later while the output is full.
// Reset (rst_ni low, asynchronous): seed, hash, length and output valid clear.
`timescale 1ns / 1ps
module murmur3_32bit_stream_hash (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration: seed register
  input  logic                       cfg_we_i,
  input  logic [mmh_pkg::WordW-1:0]  cfg_wdata_i,
  // input items
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [mmh_pkg::TdataW-1:0] s_axis_tdata,   // [31:0] data_word, [34:32] byte_count
  input  logic                       s_axis_tlast,   // last_word
  // result items
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [mmh_pkg::WordW-1:0]  m_axis_tdata    // [31:0] hash_value
);
  import mmh_pkg::*;

  mmh_cmd_t cmd;
  mmh_sts_t sts;

  mmh_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  mmh_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .word_i      (s_axis_tdata[WordW-1:0]),
    .count_i     (s_axis_tdata[WordW+CountW-1:WordW]),
    .last_i      (s_axis_tlast),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

// ===== src/mmh_ctrl.sv =====
// Controller state machine sequencing the shared multiplier of the hash.
`timescale 1ns / 1ps
`include "murmur3_32bit_stream_hash_assert.svh"
module mmh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  mmh_pkg::mmh_sts_t sts_i,
  output mmh_pkg::mmh_cmd_t cmd_o
);
  import mmh_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MIX2,
    ST_ACC,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3
  } state_e;

  state_e state_q, state_d;
  logic   ready_q, ready_d;
  logic   accept;

  assign accept        = s_axis_tvalid && ready_q;
  assign s_axis_tready = ready_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_MIX2;
      ST_MIX2: state_d = ST_ACC;
      ST_ACC:  state_d = sts_i.last ? ST_FIN1 : ST_IDLE;
      ST_FIN1: state_d = ST_FIN2;
      ST_FIN2: state_d = ST_FIN3;
      ST_FIN3: if (!sts_i.out_busy) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
    ready_d = (state_d == ST_IDLE);
  end

  // State and registered ready
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
    end else begin
      state_q <= state_d;
      ready_q <= ready_d;
    end
  end

  // Command decode
  always_comb begin
    cmd_o        = '0;
    cmd_o.accept = accept;
    cmd_o.mul2   = (state_q == ST_MIX2);
    cmd_o.acc    = (state_q == ST_ACC);
    cmd_o.fin1   = (state_q == ST_FIN1);
    cmd_o.fin2   = (state_q == ST_FIN2);
    cmd_o.fin3   = (state_q == ST_FIN3) && !sts_i.out_busy;
  end

  `MMH_ASSERT_IMP(a_cmd_onehot, clk_i, rst_ni, 1'b1, $onehot0(cmd_o), "commands overlap")
  `MMH_ASSERT_NXT(a_accept_mix2, clk_i, rst_ni, accept, cmd_o.mul2, "accepted item not mixed")
  `MMH_ASSERT_NXT(a_fin_hold, clk_i, rst_ni, state_q == ST_FIN3 && sts_i.out_busy,
                  state_q == ST_FIN3 && !s_axis_tready, "result dropped while output full")
  `MMH_ASSERT_IMP(a_ready_idle, clk_i, rst_ni, s_axis_tready, state_q == ST_IDLE,
                  "ready outside idle")

endmodule

// ===== src/mmh_datapath.sv =====
// Hash datapath: seed, running hash, length, key and finalizer registers.
`timescale 1ns / 1ps
module mmh_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [mmh_pkg::WordW-1:0] cfg_wdata_i,
  input  logic [mmh_pkg::WordW-1:0] word_i,
  input  logic [mmh_pkg::CountW-1:0] count_i,
  input  logic                      last_i,
  input  mmh_pkg::mmh_cmd_t         cmd_i,
  output mmh_pkg::mmh_sts_t         sts_o,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [mmh_pkg::WordW-1:0] out_data_o
);
  import mmh_pkg::*;

  logic [WordW-1:0]  seed_q;
  logic [WordW-1:0]  hash_q, len_q, key_q, fin_q, out_q;
  logic              in_msg_q, last_q, out_valid_q;
  logic [CountW-1:0] cnt_q, cnt_eff;
  logic [WordW-1:0]  masked, mul_a, mul_b, prod, fin_x, mixed, rot_h;

  // Effective byte count and tail mask
  always_comb begin
    cnt_eff = (count_i > FullCount || !last_i) ? FullCount : count_i;
    case (cnt_eff)
      3'd0:    masked = '0;
      3'd1:    masked = {24'd0, word_i[7:0]};
      3'd2:    masked = {16'd0, word_i[15:0]};
      3'd3:    masked = {8'd0, word_i[23:0]};
      default: masked = word_i;
    endcase
  end

  // Shared multiplier operand select (low 32 bits of product kept)
  always_comb begin
    fin_x = hash_q ^ len_q;
    mul_a = masked;
    mul_b = KeyC1;
    if (cmd_i.mul2) begin
      mul_a = key_q;
      mul_b = KeyC2;
    end else if (cmd_i.fin1) begin
      mul_a = fin_x ^ (fin_x >> 16);
      mul_b = FinM1;
    end else if (cmd_i.fin2) begin
      mul_a = fin_q ^ (fin_q >> 13);
      mul_b = FinM2;
    end
  end
  assign prod = mul_a * mul_b;

  // Full-block hash update: rotate, times five, plus constant
  assign rot_h = rotl13(hash_q ^ key_q);
  assign mixed = (rot_h << 2) + rot_h + HashMix;

  // Control-state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= '0;
      hash_q      <= '0;
      len_q       <= '0;
      in_msg_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) seed_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        last_q   <= last_i;
        in_msg_q <= 1'b1;
        if (!in_msg_q) begin
          hash_q <= seed_q;
          len_q  <= '0;
        end
      end
      if (cmd_i.acc) begin
        if (cnt_q == FullCount) hash_q <= mixed;
        else if (cnt_q != '0)   hash_q <= hash_q ^ key_q;
        len_q <= len_q + {{(WordW-CountW){1'b0}}, cnt_q};
        if (last_q) in_msg_q <= 1'b0;
      end
      if (cmd_i.fin3)       out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      key_q <= rotl15(prod);
      cnt_q <= cnt_eff;
    end
    if (cmd_i.mul2) key_q <= prod;
    if (cmd_i.fin1 || cmd_i.fin2) fin_q <= prod;
    if (cmd_i.fin3) out_q <= fin_q ^ (fin_q >> 16);
  end

  assign sts_o.last     = last_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_q;

endmodule

// ===== bench/murmur3_32bit_stream_hash_test.sv =====
// Self-checking testbench for the murmur3 x86_32 stream hash block.
`timescale 1ns / 1ps

// Tracks the running hash of the open message and the hashes still owed by the block.
class hash_board;
  logic [31:0] seed_reg;
  logic [31:0] acc_hash;
  logic [31:0] byte_len;
  bit          msg_open;
  logic [31:0] pending_hashes[$];
  int          error_count;

  function new();
    seed_reg    = '0;
    acc_hash    = '0;
    byte_len    = '0;
    msg_open    = 1'b0;
    error_count = 0;
  endfunction

  function logic [31:0] rotl(input logic [31:0] v, input int unsigned r);
    return (v << r) | (v >> (32 - r));
  endfunction

  function logic [31:0] key_mix(input logic [31:0] k);
    logic [31:0] m;
    m = k * 32'hcc9e2d51;
    m = rotl(m, 15);
    return m * 32'h1b873593;
  endfunction

  function logic [31:0] fin_mix(input logic [31:0] h);
    logic [31:0] f;
    f = h ^ (h >> 16);
    f = f * 32'h85ebca6b;
    f = f ^ (f >> 13);
    f = f * 32'hc2b2ae35;
    return f ^ (f >> 16);
  endfunction

  task report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("ERROR at %0t: %s: got %08h, expected %08h", $time, what, got, want);
    error_count++;
  endtask

  // Fold one accepted word into the open message; a last word owes one hash.
  function void note_word(input logic [31:0] word, input logic [2:0] count,
                          input logic last);
    logic [2:0]  n;
    logic [31:0] k;
    if (!msg_open) begin
      acc_hash = seed_reg;
      byte_len = '0;
      msg_open = 1'b1;
    end
    n = count;
    // counts above four, and any count on a non-last word, mean a full word
    if (n > 3'd4 || !last) n = 3'd4;
    if (n == 3'd4) begin
      acc_hash = acc_hash ^ key_mix(word);
      acc_hash = rotl(acc_hash, 13);
      acc_hash = acc_hash * 32'd5 + 32'he6546b64;
    end else if (n != 3'd0) begin
      // tail: bytes above the count are dropped, no hash rotate
      k = word & ((32'd1 << (8 * n)) - 32'd1);
      acc_hash = acc_hash ^ key_mix(k);
    end
    byte_len = byte_len + 32'(n);
    if (last) begin
      pending_hashes.push_back(fin_mix(acc_hash ^ byte_len));
      msg_open = 1'b0;
    end
  endfunction

  task check_hash(input logic [31:0] got);
    logic [31:0] want;
    if (pending_hashes.size() == 0) begin
      report("hash with no message pending", got, '0);
    end else begin
      want = pending_hashes.pop_front();
      if (got !== want) report("hash_value mismatch", got, want);
    end
  endtask
endclass

module murmur3_32bit_stream_hash_test;
  import mmh_pkg::*;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [WordW-1:0]  cfg_wdata_i   = '0;
  logic              s_axis_tvalid = 1'b0;
  logic [TdataW-1:0] s_axis_tdata  = '0;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tready = 1'b0;
  wire               s_axis_tready;
  wire               m_axis_tvalid;
  wire [WordW-1:0]   m_axis_tdata;

  hash_board   board;
  bit          steady;
  int unsigned words_sent;

  murmur3_32bit_stream_hash u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Result side: check taken hashes, stall at random outside the steady stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) board.check_hash(m_axis_tdata);
      m_axis_tready <= steady || ($urandom_range(99) >= 32);
    end
  end

  // Offer one word, with random gaps ahead of it, and wait for the handshake
  task automatic send_word(input logic [31:0] word, input logic [2:0] count,
                           input logic last);
    while (!steady && $urandom_range(99) < 32) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(TdataW - WordW - CountW){1'b0}}, count, word};
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.note_word(word, count, last);
    words_sent++;
  endtask

  // Seed changes only once the block has drained and gone quiet
  task automatic load_seed(input logic [31:0] value);
    s_axis_tvalid <= 1'b0;
    while (board.pending_hashes.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    board.seed_reg = value;
  endtask

  // Random message: mostly full words, sometimes short counts before the end
  task automatic send_message(input int unsigned n_words);
    logic [2:0] cnt;
    for (int unsigned i = 1; i <= n_words; i++) begin
      if (i == n_words) cnt = 3'($urandom_range(7));
      else if ($urandom_range(9) == 0) cnt = 3'($urandom_range(7));
      else cnt = FullCount;
      send_word($urandom, cnt, i == n_words);
    end
  endtask

  initial begin
    int unsigned phase;
    board      = new();
    steady     = 1'b0;
    words_sent = 0;
    phase      = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone empty last word, tails with garbage above the count, full words
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'hffffffff, 3'd1, 1'b1);
    send_word(32'hffffffff, 3'd2, 1'b1);
    send_word(32'hffffffff, 3'd3, 1'b1);
    send_word(32'hffffffff, FullCount, 1'b1);
    send_word(32'h00000000, FullCount, 1'b1);
    // counts above four on a last word
    send_word(32'h12345678, 3'd5, 1'b1);
    send_word(32'h12345678, 3'd6, 1'b1);
    send_word(32'h12345678, 3'd7, 1'b1);
    // short counts on non-last words, then a tail
    send_word(32'hffffffff, 3'd0, 1'b0);
    send_word(32'ha5a5a5a5, 3'd2, 1'b0);
    send_word(32'h00000000, 3'd7, 1'b0);
    send_word(32'hdeadbeef, 3'd3, 1'b1);
    // empty last word after data
    send_word(32'h00000001, FullCount, 1'b0);
    send_word(32'h80000000, FullCount, 1'b0);
    send_word(32'h00000000, 3'd0, 1'b1);
    load_seed(32'hffffffff);
    send_word(32'h00000000, 3'd0, 1'b1);
    send_word(32'hffffffff, FullCount, 1'b1);
    send_word(32'h5a5a5a5a, 3'd1, 1'b1);

    // random messages in phases, each phase under its own seed
    while (words_sent < 1000) begin
      if (words_sent >= 200 * (phase + 1)) begin
        phase++;
        case (phase)
          1:       load_seed(32'h00000000);
          3:       load_seed(32'h80000001);
          default: load_seed($urandom);
        endcase
      end
      steady = (words_sent >= 300 && words_sent < 450);
      if ($urandom_range(9) == 0) send_message($urandom_range(40, 9));
      else send_message($urandom_range(6, 1));
    end
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (board.pending_hashes.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (board.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("DONE: errors detected");
    $finish;
  end
endmodule
